>>> rtl/ssw_pkg.sv
// Shared types and constants for the servo sync-write packet framer.
package ssw_pkg;

   localparam logic [7:0] HDR_BYTE   = 8'hFF;
   localparam logic [7:0] BCAST_ID   = 8'hFE;
   localparam logic [7:0] SYNC_WRITE = 8'h83;
   localparam logic [7:0] DATA_LEN   = 8'h02;
   localparam logic [7:0] LEN_BASE   = 8'h04;

   localparam logic [6:0] SERVO_COUNT_RESET   = 7'd12;
   localparam logic [7:0] START_ADDRESS_RESET = 8'h1E;

   // Entries held between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      CSR_SERVO_COUNT   = 1'b0,
      CSR_START_ADDRESS = 1'b1
   } csr_index_type;

   // Byte slots of one entry's output run.
   typedef enum logic [3:0] {
      STEP_HDR0   = 4'd0,
      STEP_HDR1   = 4'd1,
      STEP_BCAST  = 4'd2,
      STEP_LEN    = 4'd3,
      STEP_INSTR  = 4'd4,
      STEP_ADDR   = 4'd5,
      STEP_DLEN   = 4'd6,
      STEP_ID     = 4'd7,
      STEP_POS_LO = 4'd8,
      STEP_POS_HI = 4'd9,
      STEP_CSUM   = 4'd10
   } step_type;

   typedef struct packed {
      logic [7:0]  servo_id;
      logic [15:0] goal_position;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_run;
      logic       end_of_packet;
   } rsp_payload_type;

   // One classified entry as the front hands it to the back.
   typedef struct packed {
      logic        hdr;
      logic        last;
      logic [7:0]  length;
      logic [7:0]  start_address;
      logic [7:0]  servo_id;
      logic [15:0] goal_position;
   } job_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/servo_sync_write_framer_core.sv
// Top level of the servo sync-write packet framer: front, entry queue and byte back end.
//
//   channel  direction  handshake            item
//   req      in         req_valid/req_stall  one servo entry (id, goal position)
//   rsp      out        rsp_valid/rsp_stall  one packet byte with run and packet marks
//   csr      in         csr_wr_en            register write (index, data)
//
// Each entry yields three bytes, seven more on the first entry of a packet and one
// checksum byte on the closing entry, so an entry occupies 3 to 11 bytes of output.
// The byte-wide output register lets one byte leave per cycle without stall.
// Synchronous reset restores a count of 12, start address 0x1E and the start of a packet.
// A stalled output holds its byte; entries keep entering the two-deep queue until it fills,
// and req_stall rises only while the queue is full.
module servo_sync_write_framer_core #(
   parameter int MAX_SERVOS = 83
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssw_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ssw_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_wr_en,
   input  ssw_pkg::csr_index_type   csr_index,
   input  logic [7:0]               csr_wdata
);

   ssw_pkg::job_type          front_job;
   ssw_pkg::job_type          head_job;
   ssw_pkg::queue_ctrl_type   q_ctrl;
   ssw_pkg::queue_status_type q_status;
   logic                      accept;
   logic                      back_pop;

   // An item enters whenever the queue has room.
   assign req_stall   = q_status.full;
   assign accept      = req_valid && !q_status.full;
   assign q_ctrl.push = accept;
   assign q_ctrl.pop  = back_pop;

   ssw_front #(
      .MAX_SERVOS (MAX_SERVOS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .job       (front_job)
   );

   ssw_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (q_ctrl),
      .wr_job (front_job),
      .rd_job (head_job),
      .status (q_status)
   );

   // The back end reads the queue head directly and pops it with the last byte of its run.
   ssw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_job),
      .head_valid (!q_status.empty),
      .pop        (back_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall == q_status.full)
      else $error("input stall does not follow queue occupancy");

   a_pop_with_run_end: assert property (@(posedge clock) disable iff (reset)
      back_pop |=> rsp_valid && rsp_data.end_of_run)
      else $error("entry left the queue without an end-of-run byte");

   a_run_end_popped: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !rsp_stall ##0 !q_status.empty ##1 rsp_valid && rsp_data.end_of_run
      |-> $past(back_pop))
      else $error("end-of-run byte produced without releasing its entry");

endmodule

>>> rtl/ssw_front.sv
// Front end: configuration registers, entry counting and packet classification.
module ssw_front #(
   parameter int MAX_SERVOS = 83
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  ssw_pkg::csr_index_type   csr_index,
   input  logic [7:0]               csr_wdata,
   input  logic                     accept,
   input  ssw_pkg::req_payload_type req_data,
   output ssw_pkg::job_type         job
);

   logic [6:0] servo_count_ff, servo_count_in;
   logic [7:0] start_address_ff, start_address_in;
   logic [6:0] entries_sent_ff, entries_sent_in;
   logic [6:0] cnt;
   logic [6:0] entries_next;
   logic       last;

   always_comb begin
      servo_count_in   = servo_count_ff;
      start_address_in = start_address_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ssw_pkg::CSR_SERVO_COUNT:   servo_count_in   = csr_wdata[6:0];
            ssw_pkg::CSR_START_ADDRESS: start_address_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // A count of zero acts as one, a count above the limit as the limit.
   always_comb begin
      cnt = servo_count_ff;
      if (servo_count_ff == 7'd0) begin
         cnt = 7'd1;
      end
      if (servo_count_ff > 7'(MAX_SERVOS)) begin
         cnt = 7'(MAX_SERVOS);
      end
   end

   assign entries_next = entries_sent_ff + 7'd1;
   assign last         = (entries_next >= cnt);

   always_comb begin
      entries_sent_in = entries_sent_ff;
      if (accept) begin
         entries_sent_in = last ? 7'd0 : entries_next;
      end
   end

   always_comb begin
      job.hdr           = (entries_sent_ff == 7'd0);
      job.last          = last;
      job.length        = ssw_pkg::LEN_BASE + {1'b0, cnt} + {cnt, 1'b0};
      job.start_address = start_address_ff;
      job.servo_id      = req_data.servo_id;
      job.goal_position = req_data.goal_position;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_count_ff   <= ssw_pkg::SERVO_COUNT_RESET;
         start_address_ff <= ssw_pkg::START_ADDRESS_RESET;
         entries_sent_ff  <= 7'd0;
      end else begin
         servo_count_ff   <= servo_count_in;
         start_address_ff <= start_address_in;
         entries_sent_ff  <= entries_sent_in;
      end
   end

   a_entries_in_range: assert property (@(posedge clock) disable iff (reset)
      entries_sent_ff < 7'(MAX_SERVOS))
      else $error("entry count reached the packet limit");

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> entries_sent_ff == 7'd0)
      else $error("entry count did not restart after the closing entry");

   a_count_clamped: assert property (@(posedge clock) disable iff (reset)
      cnt != 7'd0 && cnt <= 7'(MAX_SERVOS))
      else $error("effective count out of range");

endmodule

>>> rtl/ssw_queue.sv
// Short first-in first-out queue of classified entries between front and back.
module ssw_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  ssw_pkg::queue_ctrl_type   ctrl,
   input  ssw_pkg::job_type          wr_job,
   output ssw_pkg::job_type          rd_job,
   output ssw_pkg::queue_status_type status
);

   localparam int DEPTH  = ssw_pkg::QUEUE_DEPTH;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   ssw_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = ctrl.push && !status.full;
   assign do_pop       = ctrl.pop && !status.empty;
   assign rd_job       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue holds more entries than its depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      status.full && !do_pop |=> status.full)
      else $error("queue lost an entry while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      status.empty && !do_push |=> status.empty)
      else $error("queue produced an entry while empty");

endmodule

>>> rtl/ssw_back.sv
// Back end: walks each entry's byte slots, keeps the checksum and drives the output register.
module ssw_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ssw_pkg::job_type          head,
   input  logic                      head_valid,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ssw_pkg::rsp_payload_type  rsp_data
);

   logic                     active_ff, active_in;
   ssw_pkg::step_type        step_ff, step_in;
   ssw_pkg::step_type        cur_step;
   ssw_pkg::step_type        end_step;
   logic [7:0]               sum_ff, sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ssw_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                     advance;
   logic [7:0]               cur_byte;
   logic                     summed;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign cur_step = active_ff ? step_ff
                   : (head.hdr ? ssw_pkg::STEP_HDR0 : ssw_pkg::STEP_ID);
   assign end_step = head.last ? ssw_pkg::STEP_CSUM : ssw_pkg::STEP_POS_HI;

   always_comb begin
      cur_byte = ssw_pkg::HDR_BYTE;
      summed   = 1'b1;
      case (cur_step)
         ssw_pkg::STEP_HDR0:   begin cur_byte = ssw_pkg::HDR_BYTE; summed = 1'b0; end
         ssw_pkg::STEP_HDR1:   begin cur_byte = ssw_pkg::HDR_BYTE; summed = 1'b0; end
         ssw_pkg::STEP_BCAST:  cur_byte = ssw_pkg::BCAST_ID;
         ssw_pkg::STEP_LEN:    cur_byte = head.length;
         ssw_pkg::STEP_INSTR:  cur_byte = ssw_pkg::SYNC_WRITE;
         ssw_pkg::STEP_ADDR:   cur_byte = head.start_address;
         ssw_pkg::STEP_DLEN:   cur_byte = ssw_pkg::DATA_LEN;
         ssw_pkg::STEP_ID:     cur_byte = head.servo_id;
         ssw_pkg::STEP_POS_LO: cur_byte = head.goal_position[7:0];
         ssw_pkg::STEP_POS_HI: cur_byte = head.goal_position[15:8];
         ssw_pkg::STEP_CSUM:   begin cur_byte = ~sum_ff; summed = 1'b0; end
         default:              begin cur_byte = ssw_pkg::HDR_BYTE; summed = 1'b0; end
      endcase
   end

   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      if (advance) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_data_in.out_byte      = cur_byte;
            rsp_data_in.end_of_run    = (cur_step == end_step);
            rsp_data_in.end_of_packet = (cur_step == ssw_pkg::STEP_CSUM);
            if (cur_step == ssw_pkg::STEP_HDR0 || cur_step == ssw_pkg::STEP_CSUM) begin
               sum_in = 8'd0;
            end else if (summed) begin
               sum_in = sum_ff + cur_byte;
            end
            if (cur_step == end_step) begin
               pop       = 1'b1;
               active_in = 1'b0;
            end else begin
               active_in = 1'b1;
               step_in   = ssw_pkg::step_type'(cur_step + 4'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_active_has_head: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> head_valid)
      else $error("byte sequencer running without a queued entry");

   a_eop_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.end_of_packet |-> rsp_data_ff.end_of_run)
      else $error("checksum item not marked as end of run");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> step_ff <= ssw_pkg::STEP_CSUM && step_ff != ssw_pkg::STEP_HDR0)
      else $error("byte sequencer step out of range");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      advance && head_valid && cur_step == ssw_pkg::STEP_CSUM |=> sum_ff == 8'd0)
      else $error("checksum accumulator not cleared after packet close");

endmodule
